// File: rtl/mmh_pkg.sv
// Shared types, constants and helper functions for the MurmurHash64A stream hasher.
package mmh_pkg;

    localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHIFT  = 47;
    localparam logic [3:0]  FULL_BYTES = 4'd8;

    localparam int unsigned IN_TDATA_W  = 104;
    localparam int unsigned OUT_TDATA_W = 64;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_DISP,
        S_K1,
        S_K2,
        S_HMUL,
        S_FIN,
        S_EMIT
    } t_state;

    // Status of the shared multiplier as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    // Keeps the low cnt bytes of a word, cnt in 0..8.
    function automatic logic [63:0] tail_mask(input logic [3:0] cnt);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < cnt) begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    // Xor of a value with itself shifted right by the mix shift.
    function automatic logic [63:0] xor_shift(input logic [63:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

// File: rtl/mmh_mul.sv
// Iterative multiplier computing the low 64 bits of an operand times the mix constant.
module mmh_mul
    import mmh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    output t_mul_stat   o_stat,
    output logic [63:0] o_p
);

    logic [63:0] r_a;
    logic [63:0] r_acc;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    // One 32x32 multiplier: low x low, then the two cross terms into the upper half.
    always_comb begin
        mul_a = r_a[31:0];
        mul_b = MIX_MUL[31:0];
        if (i_start) begin
            mul_a = i_a[31:0];
        end else if (r_step == 2'd1) begin
            mul_b = MIX_MUL[63:32];
        end else begin
            mul_a = r_a[63:32];
        end
        prod = 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd1;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= prod;
        end else if (r_busy) begin
            r_acc[63:32] <= r_acc[63:32] + prod[31:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_p         = r_acc;

endmodule

// File: rtl/murmur64a_stream_hash.sv
// Top level of the streaming MurmurHash64A hasher.
// This block hashes keys with 64-bit MurmurHash64A. A key arrives as a run of
// items on the slave stream, each carrying eight little-endian key bytes; the
// item with tlast set ends the key and may carry 0 to 8 bytes, and an empty key
// is a single last item with a byte count of zero. The first item of a key also
// carries the total key length, which is mixed with the seed register to start
// the running hash. The seed is written through i_seed_we and i_seed_wdata and is
// sampled at the first item of each key; the user must write it only while the
// block is idle, which the block itself does not enforce. All products by the mix
// constant go through one shared 32x32 multiplier, and the block takes one item
// at a time. A full word goes through the key product, the second key product and
// the hash product, a partial tail through the hash product alone and an empty
// last item through none; the first item of a key adds the seed product. A last
// item then ends with the product of the final mix before the hash is handed to
// the output register, which lets the next item be taken while a hash still
// waits on the master stream.
module murmur64a_stream_hash
    import mmh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_seed_we,
    input  logic [63:0]            i_seed_wdata,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // data_word [63:0], byte_count [67:64], key_length [98:68], zero fill [103:99]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hash [63:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_state      r_state;
    t_state      n_state;

    logic [63:0] r_seed;
    logic [63:0] r_hash;
    logic [63:0] r_opnd;
    logic [63:0] r_word;
    logic [3:0]  r_cnt;
    logic        r_last;
    logic        r_in_key;
    logic [63:0] r_out;
    logic        r_out_valid;

    logic        accept;
    logic        mul_start;
    t_mul_stat   mul_stat;
    logic [63:0] mul_p;
    logic        out_free;
    logic        full_word;
    logic [3:0]  in_cnt;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    // A non-last item is always mixed as a whole word.
    assign full_word = !r_last || (r_cnt == FULL_BYTES);
    assign in_cnt    = (s_axis_tdata[67:64] > FULL_BYTES) ? FULL_BYTES : s_axis_tdata[67:64];

    mmh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_opnd),
        .o_stat  (mul_stat),
        .o_p     (mul_p)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = r_in_key ? S_DISP : S_INIT;
                end
            end
            S_INIT: begin
                if (mul_stat.done) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (full_word) begin
                    n_state = S_K1;
                end else if (r_cnt != 4'd0) begin
                    n_state = S_HMUL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_K1: begin
                if (mul_stat.done) begin
                    n_state = S_K2;
                end
            end
            S_K2: begin
                if (mul_stat.done) begin
                    n_state = S_HMUL;
                end
            end
            S_HMUL: begin
                if (mul_stat.done) begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (mul_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: input ready and multiplier launch.
    always_comb begin
        s_axis_tready = 1'b0;
        mul_start     = 1'b0;
        unique case (r_state) inside
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_INIT, S_K1, S_K2, S_HMUL, S_FIN: begin
                mul_start = !mul_stat.busy && !mul_stat.done;
            end
            default: begin
                s_axis_tready = 1'b0;
                mul_start     = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= '0;
            r_in_key    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
            end
            if (r_state == S_INIT && mul_stat.done) begin
                r_in_key <= 1'b1;
            end else if (r_state == S_FIN && mul_stat.done) begin
                r_in_key <= 1'b0;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: the hash, the multiplier operand and the captured item.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_word <= s_axis_tdata[63:0];
                    r_cnt  <= in_cnt;
                    r_last <= s_axis_tlast;
                    r_opnd <= {33'd0, s_axis_tdata[98:68]};
                end
            end
            S_INIT: begin
                if (mul_stat.done) begin
                    r_hash <= r_seed ^ mul_p;
                end
            end
            S_DISP: begin
                if (full_word) begin
                    r_opnd <= r_word;
                end else if (r_cnt != 4'd0) begin
                    r_opnd <= r_hash ^ (r_word & tail_mask(r_cnt));
                end else begin
                    r_opnd <= xor_shift(r_hash);
                end
            end
            S_K1: begin
                if (mul_stat.done) begin
                    r_opnd <= xor_shift(mul_p);
                end
            end
            S_K2: begin
                if (mul_stat.done) begin
                    r_opnd <= r_hash ^ mul_p;
                end
            end
            S_HMUL: begin
                if (mul_stat.done) begin
                    r_hash <= mul_p;
                    r_opnd <= xor_shift(mul_p);
                end
            end
            S_FIN: begin
                if (mul_stat.done) begin
                    r_hash <= xor_shift(mul_p);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out <= r_hash;
                end
            end
            default: begin
                r_opnd <= r_opnd;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

// File: rtl/mmh_check.sv
// Port-level checker for the MurmurHash64A stream hasher and its bind statement.
module mmh_check
    import mmh_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   i_s_tready,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata
);

    // The block works on one item at a time, so it drops ready after taking one.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready
    ) else $error("input ready stayed high after an accepted item");

    // A new hash only appears out of a busy phase, never straight from idle.
    a_result_from_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> $past(!i_s_tready)
    ) else $error("output valid rose while the block was idle");

    // A stalled hash is held until taken.
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata))
    ) else $error("stalled output item changed or vanished");

endmodule

bind murmur64a_stream_hash mmh_check u_mmh_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

// File: tb/murmur64a_hash_checker.sv
// Checker for the MurmurHash64A stream hasher: predicts each hash and compares it on the output.
`timescale 1ns / 100ps

module murmur64a_hash_checker
    import mmh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_seed_we,
    input  logic [63:0]            i_seed_wdata,

    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    // data_word [63:0], byte_count [67:64], key_length [98:68], zero fill [103:99]
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                   i_in_tlast,

    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    // hash [63:0]
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,

    output int                     o_mismatches,
    output int                     o_outstanding
);

    logic [63:0] seed_copy;
    logic [63:0] running_hash;
    logic        in_key;
    logic [63:0] expected_hashes[$];
    int          mismatch_total;

    always @(posedge i_clk) begin : predict_and_check
        logic [63:0] word;
        logic [3:0]  used;
        logic [63:0] k;
        logic [63:0] h;
        logic [63:0] want;

        if (!i_rst_n) begin
            seed_copy    = '0;
            running_hash = '0;
            in_key       = 1'b0;
            expected_hashes.delete();
            mismatch_total = 0;
        end else begin
            if (i_seed_we) begin
                seed_copy = i_seed_wdata;
            end

            // A result accepted at this edge can only belong to an earlier item.
            if (i_out_tvalid && i_out_tready) begin
                if (expected_hashes.size() == 0) begin
                    $error("hash: expected none, actual %h", i_out_tdata);
                    mismatch_total++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (i_out_tdata !== want) begin
                        $error("hash: expected %h, actual %h", want, i_out_tdata);
                        mismatch_total++;
                    end
                end
            end

            if (i_in_tvalid && i_in_tready) begin
                word = i_in_tdata[63:0];
                used = i_in_tdata[67:64];
                if (used > FULL_BYTES) begin
                    used = FULL_BYTES;
                end
                if (!in_key) begin
                    running_hash = seed_copy ^ ({33'd0, i_in_tdata[98:68]} * MIX_MUL);
                    in_key       = 1'b1;
                end
                h = running_hash;
                // Non-last items always fold a whole word, whatever their byte count says.
                if (!i_in_tlast || used == FULL_BYTES) begin
                    k = word * MIX_MUL;
                    k = k ^ (k >> MIX_SHIFT);
                    k = k * MIX_MUL;
                    h = (h ^ k) * MIX_MUL;
                end else if (used != 4'd0) begin
                    h = (h ^ (word & ((64'd1 << (int'(used) * 8)) - 64'd1))) * MIX_MUL;
                end
                if (i_in_tlast) begin
                    h = h ^ (h >> MIX_SHIFT);
                    h = h * MIX_MUL;
                    h = h ^ (h >> MIX_SHIFT);
                    expected_hashes.push_back(h);
                    in_key = 1'b0;
                end
                running_hash = h;
            end
        end

        o_mismatches  <= mismatch_total;
        o_outstanding <= expected_hashes.size();
    end

endmodule

// File: tb/murmur64a_stream_hash_test.sv
// Top of the testbench for the MurmurHash64A stream hasher: stimulus, idling and verdict.
`timescale 1ns / 100ps

module murmur64a_stream_hash_test;

    import mmh_pkg::*;

    // Four nanosecond clock and the length of the reset hold.
    localparam int RESET_CYCLES = 3;
    // Pause that comfortably covers any work still in flight after the last hash, even
    // for the slowest item (first, full last word, final mix, hand-off).
    localparam int SETTLE_CYCLES = 48;
    // Long receiver hold-off, long enough for the block to fill and stall its input.
    localparam int HOLD_CYCLES = 400;
    // Random items per idling phase.
    localparam int PHASE_ITEMS = 380;
    // Watchdog cycle limit for the whole run.
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_seed_we     = 1'b0;
    logic [63:0]            i_seed_wdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // data_word [63:0], byte_count [67:64], key_length [98:68], zero fill [103:99]
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // hash [63:0]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Idling percentages of the current phase, read by the sender task and the receiver.
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    // Raised by the stimulus to ask the receiver for one long hold-off; the receiver clears it.
    bit          hold_req       = 1'b0;

    int items_sent  = 0;
    int cycle_count = 0;
    int mismatches;
    int outstanding;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    murmur64a_stream_hash dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_we     (i_seed_we),
        .i_seed_wdata  (i_seed_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    murmur64a_hash_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_we     (i_seed_we),
        .i_seed_wdata  (i_seed_wdata),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tlast    (s_axis_tlast),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Outside a hold-off the receiver decides tready once per cycle. During a hold-off
    // it keeps tready low for HOLD_CYCLES, counted here so that the sender can keep
    // offering items meanwhile and the block backs up into its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Offers one item and returns at the edge where it is taken. Idle cycles go in
    // front of the item, so tvalid only drops when the sender actually pauses and
    // back-to-back items keep it high without a second assignment in one step.
    task automatic push_item(input logic [63:0] word, input logic [3:0] used,
                             input logic [30:0] key_len, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, key_len, used, word};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Sends one key of nbytes bytes. A noisy key carries junk byte counts on its
    // non-last items and a count of 8 to 15 on a full last word; the key length
    // field of the first item is whatever the caller gives, later ones are random.
    task automatic send_key(input int nbytes, input logic [30:0] len_field, input bit noisy);
        int         n_items;
        int         tail;
        logic [3:0] used;
        logic       is_last;

        n_items = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
        tail    = nbytes % 8;
        for (int i = 0; i < n_items; i++) begin
            is_last = (i == n_items - 1);
            if (!is_last) begin
                used = noisy ? 4'($urandom_range(15)) : FULL_BYTES;
            end else if (nbytes == 0) begin
                used = 4'd0;
            end else if (tail != 0) begin
                used = 4'(tail);
            end else begin
                used = noisy ? 4'($urandom_range(8, 15)) : FULL_BYTES;
            end
            push_item(rand_word(), used, (i == 0) ? len_field : 31'($urandom), is_last);
        end
    endtask

    // Most keys are short so that many hashes come out; a few run to fifty words.
    task automatic send_random_key();
        int          nbytes;
        int unsigned pick;
        bit          noisy;

        pick = $urandom_range(99);
        if (pick < 85) begin
            nbytes = $urandom_range(40);
        end else if (pick < 97) begin
            nbytes = $urandom_range(120);
        end else begin
            nbytes = $urandom_range(400);
        end
        noisy = ($urandom_range(99) < 15);
        send_key(nbytes, noisy ? 31'($urandom) : 31'(nbytes), noisy);
    endtask

    // Stops offering items, waits for every predicted hash, then lets the block
    // finish any non-last item it may still be folding in.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        i_seed_we    <= 1'b1;
        i_seed_wdata <= value;
        @(posedge i_clk);
        i_seed_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct,
                             input logic [63:0] seed_value);
        int goal;

        write_seed(seed_value);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) begin
            send_random_key();
        end
        settle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling, seed still at its reset value of zero.
        // An empty key only gets the final mix of the seed.
        push_item(64'd0, 4'd0, 31'd0, 1'b1);
        // A single full last word, mixed as a word with no tail.
        push_item('1, FULL_BYTES, 31'd8, 1'b1);
        // One-byte and seven-byte tails; the bytes above the count must be ignored.
        push_item('1, 4'd1, 31'd1, 1'b1);
        push_item(rand_word(), 4'd7, 31'd7, 1'b1);
        // Two full words.
        push_item(64'd0, FULL_BYTES, 31'd16, 1'b0);
        push_item('1, FULL_BYTES, 31'd0, 1'b1);
        // A short non-last item still counts as a whole word.
        push_item(rand_word(), 4'd3, 31'd8, 1'b0);
        push_item(rand_word(), 4'd5, 31'd0, 1'b1);
        // Oversized byte counts behave like eight, with the largest key length.
        push_item(rand_word(), 4'd15, 31'h7fff_ffff, 1'b1);
        push_item(rand_word(), 4'd0, 31'd0, 1'b0);
        push_item(rand_word(), 4'd9, 31'h2aaa_aaaa, 1'b1);
        settle();

        // A seed written in the middle of a key only applies from the next key on.
        write_seed('1);
        push_item(rand_word(), FULL_BYTES, 31'd20, 1'b0);
        settle();
        write_seed(64'h0123_4567_89ab_cdef);
        push_item(rand_word(), 4'd4, 31'h5555_5555, 1'b1);
        push_item(64'd0, 4'd0, 31'd0, 1'b1);
        push_item(rand_word(), FULL_BYTES, 31'd12, 1'b0);
        push_item(rand_word(), 4'd4, 31'd12, 1'b1);
        settle();
        write_seed(64'h8000_0000_0000_0000);
        push_item(rand_word(), 4'd2, 31'd2, 1'b1);
        settle();

        // Random part, one phase per idling pattern, each with its own seed.
        run_phase(0, 0, rand_word());

        // Back-pressure: the receiver holds off for a long stretch while keys keep
        // coming, so the output register fills and the block stops taking items.
        src_idle_pct = 0;
        hold_req     = 1'b1;
        repeat (16) begin
            send_key($urandom_range(1, 24), 31'($urandom_range(1, 24)), 1'b0);
        end
        settle();

        run_phase(52, 0, 64'd0);
        run_phase(0, 52, '1);
        run_phase(11, 11, rand_word());

        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mmh_pkg.sv
rtl/mmh_mul.sv
rtl/murmur64a_stream_hash.sv
rtl/mmh_check.sv
tb/murmur64a_hash_checker.sv
tb/murmur64a_stream_hash_test.sv
